// ===== src/imbre_pkg.sv =====
// ----------------------------------------------------------------------------
// imbre_pkg - shared types and constants of the in-memory bitwise row engine
// Word, row and field types, mode and operation codes, word group layout and
// the control bundle handed from the sequencer to the word unit.
// ----------------------------------------------------------------------------
package imbre_pkg;

	localparam int ROW_COUNT_DEF = 128;
	localparam int WORDS_PER_ROW = 16;
	localparam int WORD_BITS     = 32;
	localparam int ROW_IN_W      = 7;
	localparam int WORD_IDX_W    = $clog2(WORDS_PER_ROW);
	localparam int ROW_IN_SPAN   = 2 ** ROW_IN_W;

	typedef logic [WORD_BITS-1:0]  word_t;
	typedef logic [ROW_IN_W-1:0]   row_in_t;
	typedef logic [WORD_IDX_W-1:0] word_idx_t;
	typedef logic [3:0]            op_t;
	typedef logic [1:0]            mode_t;
	typedef logic [3:0]            bank_mask_t;

	localparam mode_t MODE_WRITE = 2'd0;
	localparam mode_t MODE_READ  = 2'd1;
	localparam mode_t MODE_EXEC  = 2'd2;

	localparam op_t OP_AND  = 4'd1;
	localparam op_t OP_OR   = 4'd2;
	localparam op_t OP_XOR  = 4'd3;
	localparam op_t OP_COPY = 4'd4;
	localparam op_t OP_NOT  = 4'd5;
	localparam op_t OP_SHL1 = 4'd6;
	localparam op_t OP_SHL4 = 4'd7;

	localparam word_idx_t WORD_LAST = word_idx_t'(WORDS_PER_ROW - 1);

	// first word of each bank group: 0-7, 8-9, 10-13, 14-15
	localparam word_idx_t GROUP_BASE [4] = '{4'd0, 4'd8, 4'd10, 4'd14};

	typedef struct packed {
		logic en;   // a selected word is being written back
		logic clr;  // new command: drop both carries
		op_t  op;
	} alu_ctl_t;

	function automatic logic [1:0] word_group(word_idx_t w);
		logic [1:0] g;
		if (w < GROUP_BASE[1]) begin
			g = 2'd0;
		end else if (w < GROUP_BASE[2]) begin
			g = 2'd1;
		end else if (w < GROUP_BASE[3]) begin
			g = 2'd2;
		end else begin
			g = 2'd3;
		end
		return g;
	endfunction

endpackage

// ===== src/in_memory_bitwise_row_engine.sv =====
// ----------------------------------------------------------------------------
// in_memory_bitwise_row_engine - bitwise row operations inside a word store
// Bus word write, bus word read and row commands over a store of
// ROW_COUNT rows by 16 words of 32 bits.
//
//   channel   handshake          beat contents
//   -------   ----------------   ------------------------------------------
//   item      start & !busy      mode, access_row, access_word, write_data,
//                                row_a, row_b, row_c, operation, bank_mask
//   result    done (one cycle)   read_data
//
// A bus write passes through S_WRITE and a bus read through S_READ and
// S_READ_WAIT before the result beat; an unused mode answers from idle.
// A command walks all 16 word offsets, S_CMD_A then S_CMD_B for each, since
// A and B share the single read port of the store; the result beat follows
// S_CMD_LAST, busy drops with it; write-back overlaps the next word's reads.
// Reset clears the sequencer and carries; the store itself is not cleared.
// The receiver cannot stall, so done is a single-cycle pulse.
// ----------------------------------------------------------------------------
module in_memory_bitwise_row_engine #(
	parameter int ROW_COUNT = imbre_pkg::ROW_COUNT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  imbre_pkg::mode_t       mode,
	input  imbre_pkg::row_in_t     access_row,
	input  imbre_pkg::word_idx_t   access_word,
	input  imbre_pkg::word_t       write_data,
	input  imbre_pkg::row_in_t     row_a,
	input  imbre_pkg::row_in_t     row_b,
	input  imbre_pkg::row_in_t     row_c,
	input  imbre_pkg::op_t         operation,
	input  imbre_pkg::bank_mask_t  bank_mask,
	output logic                   done,
	output imbre_pkg::word_t       read_data
);
	import imbre_pkg::*;

	localparam int RIDX_W = $clog2(ROW_COUNT);
	localparam int ADDR_W = RIDX_W + WORD_IDX_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WRITE,
		S_READ,
		S_READ_WAIT,
		S_CMD_A,
		S_CMD_B,
		S_CMD_LAST
	} state_t;

	// row numbers wrap modulo ROW_COUNT: a constant table over all 7-bit rows
	logic [RIDX_W-1:0] row_lut [ROW_IN_SPAN];

	for (genvar i = 0; i < ROW_IN_SPAN; i++) begin : g_row_lut
		localparam int ROW_WRAPPED = i % ROW_COUNT;
		assign row_lut[i] = RIDX_W'(ROW_WRAPPED);
	end

	state_t            state_q;
	logic              done_q;
	word_t             read_data_q;
	word_idx_t         word_q;
	logic              wb_s2;
	word_idx_t         word_s2;
	word_t             a_s1;

	logic [RIDX_W-1:0] acc_row_q;
	word_idx_t         acc_word_q;
	word_t             wdata_q;
	logic [RIDX_W-1:0] row_a_q;
	logic [RIDX_W-1:0] row_b_q;
	logic [RIDX_W-1:0] row_c_q;
	op_t               op_q;
	bank_mask_t        mask_q;

	logic              accept;
	logic              sel_word;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	word_t             rd_data;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	word_t             wr_data;
	alu_ctl_t          alu_ctl;
	word_t             alu_c;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign done      = done_q;
	assign read_data = read_data_q;

	// is the current word offset in a selected bank group
	assign sel_word = mask_q[word_group(word_q)];

	// read port: bus read, then A and B of the current word
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = {acc_row_q, acc_word_q};
		case (state_q)
			S_READ: begin
				rd_en = 1'b1;
			end
			S_CMD_A: begin
				rd_en   = 1'b1;
				rd_addr = {row_a_q, word_q};
			end
			S_CMD_B: begin
				rd_en   = 1'b1;
				rd_addr = {row_b_q, word_q};
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// write port: bus write, or write-back of the previous word to row C.
	// The write-back always targets another offset than the reads beside it,
	// so no forwarding is needed.
	always_comb begin
		wr_en = (state_q == S_WRITE) || wb_s2;
		if (state_q == S_WRITE) begin
			wr_addr = {acc_row_q, acc_word_q};
			wr_data = wdata_q;
		end else begin
			wr_addr = {row_c_q, word_s2};
			wr_data = alu_c;
		end
	end

	always_comb begin
		alu_ctl.en  = wb_s2;
		alu_ctl.clr = accept && (mode == MODE_EXEC);
		alu_ctl.op  = op_q;
	end

	imbre_store #(
		.ROW_COUNT (ROW_COUNT)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// B arrives on rd_data in the cycle after S_CMD_B, A waits in a_s1
	imbre_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (alu_ctl),
		.a      (a_s1),
		.b      (rd_data),
		.c      (alu_c)
	);

	// sequencer: state and the registered result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			done_q      <= 1'b0;
			read_data_q <= '0;
			word_q      <= '0;
			wb_s2       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			wb_s2  <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						word_q <= '0;
						case (mode)
							MODE_WRITE: state_q <= S_WRITE;
							MODE_READ:  state_q <= S_READ;
							MODE_EXEC:  state_q <= S_CMD_A;
							default: begin
								// unused mode: answer zero at once
								done_q      <= 1'b1;
								read_data_q <= '0;
							end
						endcase
					end
				end
				S_WRITE: begin
					done_q      <= 1'b1;
					read_data_q <= '0;
					state_q     <= S_IDLE;
				end
				S_READ: begin
					state_q <= S_READ_WAIT;
				end
				S_READ_WAIT: begin
					done_q      <= 1'b1;
					read_data_q <= rd_data;
					state_q     <= S_IDLE;
				end
				S_CMD_A: begin
					state_q <= S_CMD_B;
				end
				S_CMD_B: begin
					// hand the word on to write-back only if its group is selected
					wb_s2  <= sel_word;
					word_q <= word_q + 1'b1;
					if (word_q == WORD_LAST) begin
						state_q <= S_CMD_LAST;
					end else begin
						state_q <= S_CMD_A;
					end
				end
				S_CMD_LAST: begin
					// last write-back happens in this cycle
					done_q      <= 1'b1;
					read_data_q <= '0;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// capture the item fields; rows are wrapped on the way in
	always_ff @(posedge clk) begin
		if (accept) begin
			acc_row_q  <= row_lut[access_row];
			acc_word_q <= access_word;
			wdata_q    <= write_data;
			row_a_q    <= row_lut[row_a];
			row_b_q    <= row_lut[row_b];
			row_c_q    <= row_lut[row_c];
			op_q       <= operation;
			mask_q     <= bank_mask;
		end
		if (state_q == S_CMD_B) begin
			a_s1    <= rd_data;
			word_s2 <= word_q;
		end
	end

endmodule

// ===== src/imbre_store.sv =====
// ----------------------------------------------------------------------------
// imbre_store - word store
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module imbre_store #(
	parameter int  ROW_COUNT = imbre_pkg::ROW_COUNT_DEF,
	localparam int ADDR_W    = $clog2(ROW_COUNT) + imbre_pkg::WORD_IDX_W
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [ADDR_W-1:0]  wr_addr,
	input  imbre_pkg::word_t   wr_data,
	input  logic               rd_en,
	input  logic [ADDR_W-1:0]  rd_addr,
	output imbre_pkg::word_t   rd_data
);
	import imbre_pkg::*;

	localparam int DEPTH = ROW_COUNT * WORDS_PER_ROW;

	word_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== src/imbre_alu.sv =====
// ----------------------------------------------------------------------------
// imbre_alu - word operation unit
// Combines the A and B words and keeps the shift carries between words.
// ----------------------------------------------------------------------------
module imbre_alu (
	input  logic                 clk,
	input  logic                 arst_n,
	input  imbre_pkg::alu_ctl_t  ctl,
	input  imbre_pkg::word_t     a,
	input  imbre_pkg::word_t     b,
	output imbre_pkg::word_t     c
);
	import imbre_pkg::*;

	logic       carry1_q;
	logic [3:0] carry4_q;

	always_comb begin
		case (ctl.op)
			OP_AND:  c = a & b;
			OP_OR:   c = a | b;
			OP_XOR:  c = a ^ b;
			OP_COPY: c = a;
			OP_NOT:  c = ~a;
			OP_SHL1: c = {a[WORD_BITS-2:0], carry1_q};
			OP_SHL4: c = {a[WORD_BITS-5:0], carry4_q};
			default: c = a;
		endcase
	end

	// advance the carries only on words that are written back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry1_q <= 1'b0;
			carry4_q <= 4'h0;
		end else if (ctl.clr) begin
			carry1_q <= 1'b0;
			carry4_q <= 4'h0;
		end else if (ctl.en) begin
			if (ctl.op == OP_SHL1) begin
				carry1_q <= a[WORD_BITS-1];
			end
			if (ctl.op == OP_SHL4) begin
				carry4_q <= a[WORD_BITS-1:WORD_BITS-4];
			end
		end
	end

endmodule

// ===== verif/in_memory_bitwise_row_engine_tb.sv =====
// ----------------------------------------------------------------------------
// in_memory_bitwise_row_engine_tb - self-checking bench for the row engine
// Drives bus writes, bus reads and row commands through the start/busy
// handshake. A scoreboard keeps its own copy of the word store, predicts
// read_data for every accepted beat and checks each done beat in order.
// Stimulus only reads store words that have been written before.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module in_memory_bitwise_row_engine_tb;

	import imbre_pkg::*;

	localparam int ROWS     = ROW_COUNT_DEF;
	localparam int CELLS    = ROWS * WORDS_PER_ROW;
	localparam int TAIL_CYC = 40;       // longer than a command needs to its done beat
	localparam int RAND_BEATS = 1000;

	// codes with no name in the package
	localparam mode_t      MODE_UNUSED = 2'd3;
	localparam op_t        OP_UNDEF_LO = 4'd0;
	localparam op_t        OP_UNDEF_HI = 4'd15;
	localparam bank_mask_t MASK_NONE   = 4'b0000;
	localparam bank_mask_t MASK_TOP    = 4'b1000;
	localparam bank_mask_t MASK_UPPER  = 4'b1100;

	typedef struct {
		mode_t      mode;
		row_in_t    access_row;
		word_idx_t  access_word;
		word_t      write_data;
		row_in_t    row_a;
		row_in_t    row_b;
		row_in_t    row_c;
		op_t        operation;
		bank_mask_t bank_mask;
	} row_beat_t;

	// ------------------------------------------------------------------------
	// Scoreboard: private copy of the store, queue of read_data still due
	// ------------------------------------------------------------------------
	class row_engine_scoreboard;
		word_t store_copy [CELLS];
		word_t read_data_due [$];
		int    faults;

		static function bit selects(bank_mask_t mask, int w);
			int g;
			g = (w < 8) ? 0 : (w < 10) ? 1 : (w < 14) ? 2 : 3;
			return mask[g];
		endfunction

		static function int cell_of(row_in_t row, int w);
			return (int'(row) % ROWS) * WORDS_PER_ROW + w;
		endfunction

		// walk selected words upwards; A and B are read before C is written
		function void run_rows(row_beat_t b);
			word_t      a;
			word_t      c;
			logic       carry1;
			logic [3:0] carry4;
			carry1 = 1'b0;
			carry4 = 4'h0;
			for (int w = 0; w < WORDS_PER_ROW; w++) begin
				if (!selects(b.bank_mask, w)) continue;
				a = store_copy[cell_of(b.row_a, w)];
				case (b.operation)
				OP_AND: c = a & store_copy[cell_of(b.row_b, w)];
				OP_OR:  c = a | store_copy[cell_of(b.row_b, w)];
				OP_XOR: c = a ^ store_copy[cell_of(b.row_b, w)];
				OP_NOT: c = ~a;
				OP_SHL1: begin
					c      = {a[30:0], carry1};
					carry1 = a[31];
				end
				OP_SHL4: begin
					c      = {a[27:0], carry4};
					carry4 = a[31:28];
				end
				default: c = a;
				endcase
				store_copy[cell_of(b.row_c, w)] = c;
			end
		endfunction

		function void note_beat(row_beat_t b);
			word_t rd;
			rd = '0;
			case (b.mode)
			MODE_WRITE: store_copy[cell_of(b.access_row, b.access_word)] = b.write_data;
			MODE_READ:  rd = store_copy[cell_of(b.access_row, b.access_word)];
			MODE_EXEC:  run_rows(b);
			default: ;
			endcase
			read_data_due.push_back(rd);
		endfunction

		function void check_read_data(word_t got);
			word_t want;
			if (read_data_due.size() == 0) begin
				if (faults < 10) $display("%0t: done beat with nothing due, read_data %h",
					$realtime, got);
				faults++;
				return;
			end
			want = read_data_due.pop_front();
			if (got !== want) begin
				if (faults < 10) $display("%0t: read_data expected %h got %h",
					$realtime, want, got);
				faults++;
			end
		endfunction

		function int pending();
			return read_data_due.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Block signals, all known from time zero
	// ------------------------------------------------------------------------
	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       start       = 1'b0;
	mode_t      mode        = MODE_WRITE;
	row_in_t    access_row  = '0;
	word_idx_t  access_word = '0;
	word_t      write_data  = '0;
	row_in_t    row_a       = '0;
	row_in_t    row_b       = '0;
	row_in_t    row_c       = '0;
	op_t        operation   = OP_AND;
	bank_mask_t bank_mask   = MASK_NONE;
	logic       busy;
	logic       done;
	word_t      read_data;

	row_engine_scoreboard sb = new();

	// stimulus bookkeeping: which store words hold a defined value
	bit cell_written [CELLS];
	int written_cells [$];
	int hot_rows [8];
	bit no_idle = 1'b0;

	in_memory_bitwise_row_engine #(
		.ROW_COUNT(ROWS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.access_row (access_row),
		.access_word(access_word),
		.write_data (write_data),
		.row_a      (row_a),
		.row_b      (row_b),
		.row_c      (row_c),
		.operation  (operation),
		.bank_mask  (bank_mask),
		.done       (done),
		.read_data  (read_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Monitor: check the done beat first, then note any beat taken this edge
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		row_beat_t seen;
		if (arst_n) begin
			if (done) sb.check_read_data(read_data);
			if (start && !busy) begin
				seen.mode        = mode;
				seen.access_row  = access_row;
				seen.access_word = access_word;
				seen.write_data  = write_data;
				seen.row_a       = row_a;
				seen.row_b       = row_b;
				seen.row_c       = row_c;
				seen.operation   = operation;
				seen.bank_mask   = bank_mask;
				sb.note_beat(seen);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	function automatic void mark_written(row_in_t row, int w);
		int idx;
		idx = row_engine_scoreboard::cell_of(row, w);
		if (!cell_written[idx]) begin
			cell_written[idx] = 1'b1;
			written_cells.push_back(idx);
		end
	endfunction

	// every selected word of the row has been written
	function automatic bit row_ready(row_in_t row, bank_mask_t mask);
		for (int w = 0; w < WORDS_PER_ROW; w++)
			if (row_engine_scoreboard::selects(mask, w) &&
				!cell_written[row_engine_scoreboard::cell_of(row, w)]) return 1'b0;
		return 1'b1;
	endfunction

	function automatic int first_hole(row_in_t row, bank_mask_t mask);
		for (int w = 0; w < WORDS_PER_ROW; w++)
			if (row_engine_scoreboard::selects(mask, w) &&
				!cell_written[row_engine_scoreboard::cell_of(row, w)]) return w;
		return 0;
	endfunction

	// mostly a handful of busy rows, so that commands find defined sources
	function automatic row_in_t pick_row();
		if ($urandom_range(0, 9) < 8) return row_in_t'(hot_rows[$urandom_range(0, 7)]);
		return row_in_t'($urandom_range(0, ROWS - 1));
	endfunction

	function automatic word_t pick_data();
		case ($urandom_range(0, 7))
		0:       return '0;
		1:       return '1;
		2:       return word_t'(1) << $urandom_range(0, WORD_BITS - 1);
		default: return word_t'($urandom);
		endcase
	endfunction

	function automatic row_beat_t make_beat(mode_t m, int arow, int aword, word_t data,
		int ra, int rb, int rc, op_t op, bank_mask_t mask);
		row_beat_t b;
		b.mode        = m;
		b.access_row  = row_in_t'(arow);
		b.access_word = word_idx_t'(aword);
		b.write_data  = data;
		b.row_a       = row_in_t'(ra);
		b.row_b       = row_in_t'(rb);
		b.row_c       = row_in_t'(rc);
		b.operation   = op;
		b.bank_mask   = mask;
		return b;
	endfunction

	function automatic row_beat_t random_beat();
		row_beat_t b;
		int        pick;
		int        idx;
		int        tries;
		row_in_t   ra;
		row_in_t   rb;
		// fill every field first; unused ones still toggle on the pins
		b = make_beat(mode_t'($urandom), $urandom, $urandom, word_t'($urandom),
			$urandom, $urandom, $urandom, op_t'($urandom), bank_mask_t'($urandom));
		pick = $urandom_range(0, 99);
		if (pick >= 97) begin
			b.mode = MODE_UNUSED;
		end else if (pick < 35 || (pick < 65 && written_cells.size() == 0)) begin
			b.mode        = MODE_WRITE;
			b.access_row  = pick_row();
			b.write_data  = pick_data();
		end else if (pick < 65) begin
			idx           = written_cells[$urandom_range(0, written_cells.size() - 1)];
			b.mode        = MODE_READ;
			b.access_row  = row_in_t'(idx / WORDS_PER_ROW);
			b.access_word = word_idx_t'(idx % WORDS_PER_ROW);
		end else begin
			b.mode = MODE_EXEC;
			if ($urandom_range(0, 4) != 0) b.operation = op_t'($urandom_range(OP_AND, OP_SHL4));
			ra    = pick_row();
			tries = 0;
			while (!row_ready(ra, b.bank_mask) && tries < 12) begin
				ra = pick_row();
				tries++;
			end
			rb    = pick_row();
			tries = 0;
			while (!row_ready(rb, b.bank_mask) && tries < 12) begin
				rb = pick_row();
				tries++;
			end
			// no defined source yet: fill a hole in it instead
			if (!row_ready(ra, b.bank_mask) || !row_ready(rb, b.bank_mask)) begin
				b.mode        = MODE_WRITE;
				b.access_row  = row_ready(ra, b.bank_mask) ? rb : ra;
				b.access_word = word_idx_t'(first_hole(b.access_row, b.bank_mask));
				b.write_data  = pick_data();
			end else begin
				b.row_a = ra;
				b.row_b = rb;
				case ($urandom_range(0, 5))
				0:       b.row_c = ra;
				1:       b.row_c = row_in_t'($urandom_range(0, ROWS - 1));
				default: b.row_c = pick_row();
				endcase
			end
		end
		return b;
	endfunction

	// Hold start high across back-to-back beats; drop it only for a gap.
	task automatic issue(row_beat_t b);
		int gap;
		if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (b.mode == MODE_WRITE) mark_written(b.access_row, b.access_word);
		if (b.mode == MODE_EXEC)
			for (int w = 0; w < WORDS_PER_ROW; w++)
				if (row_engine_scoreboard::selects(b.bank_mask, w)) mark_written(b.row_c, w);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		mode        <= b.mode;
		access_row  <= b.access_row;
		access_word <= b.access_word;
		write_data  <= b.write_data;
		row_a       <= b.row_a;
		row_b       <= b.row_b;
		row_c       <= b.row_c;
		operation   <= b.operation;
		bank_mask   <= b.bank_mask;
		start       <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : stimulus
		op_t       every_op [9] = '{OP_AND, OP_OR, OP_XOR, OP_COPY, OP_NOT,
			OP_SHL1, OP_SHL4, OP_UNDEF_LO, OP_UNDEF_HI};
		row_beat_t b;
		int        taken;

		hot_rows[0] = 0;
		hot_rows[1] = ROWS - 1;
		for (int i = 2; i < 8; i++) hot_rows[i] = $urandom_range(0, ROWS - 1);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// seed the upper groups of rows 0 and 127 with edge patterns
		issue(make_beat(MODE_WRITE, 0,   10, 32'hFFFF_FFFF, 0, 0, 0, OP_AND, MASK_NONE));
		issue(make_beat(MODE_WRITE, 0,   11, 32'h8000_0000, 0, 0, 0, OP_AND, MASK_NONE));
		issue(make_beat(MODE_WRITE, 0,   12, 32'h0000_0001, 0, 0, 0, OP_AND, MASK_NONE));
		issue(make_beat(MODE_WRITE, 0,   13, 32'hF000_000F, 0, 0, 0, OP_AND, MASK_NONE));
		issue(make_beat(MODE_WRITE, 0,   14, 32'hA5A5_A5A5, 0, 0, 0, OP_AND, MASK_NONE));
		issue(make_beat(MODE_WRITE, 0,   15, 32'hFFFF_FFFF, 0, 0, 0, OP_AND, MASK_NONE));
		issue(make_beat(MODE_WRITE, 127, 14, 32'h0000_0000, 0, 0, 0, OP_AND, MASK_NONE));
		issue(make_beat(MODE_WRITE, 127, 15, 32'h5A5A_5A5A, 0, 0, 0, OP_AND, MASK_NONE));

		// every named operation code and two unknown ones, on the last group
		for (int i = 0; i < 9; i++)
			issue(make_beat(MODE_EXEC, 0, 0, '0, 0, 127, (i < 7) ? 3 : 4, every_op[i],
				MASK_TOP));

		// carries cross the group boundary between words 13 and 14
		issue(make_beat(MODE_EXEC, 0, 0, '0, 0, 0, 5, OP_SHL1, MASK_UPPER));
		issue(make_beat(MODE_EXEC, 0, 0, '0, 0, 0, 6, OP_SHL4, MASK_UPPER));
		// empty mask leaves row 127 alone
		issue(make_beat(MODE_EXEC, 0, 0, '0, 0, 0, 127, OP_AND, MASK_NONE));
		// destination is also the source: each word read before it is written
		issue(make_beat(MODE_EXEC, 0, 0, '0, 0, 0, 0, OP_SHL1, MASK_UPPER));
		issue(make_beat(MODE_READ, 5,   14, '1, 127, 127, 127, OP_UNDEF_HI, MASK_UPPER));
		issue(make_beat(MODE_READ, 6,   15, '0, 0, 0, 0, OP_AND, MASK_NONE));
		issue(make_beat(MODE_READ, 0,   13, '0, 0, 0, 0, OP_AND, MASK_NONE));
		issue(make_beat(MODE_READ, 127, 15, '0, 0, 0, 0, OP_AND, MASK_NONE));
		issue(make_beat(MODE_UNUSED, 127, 15, '1, 127, 127, 127, OP_UNDEF_HI, 4'hF));

		// random traffic; beats in the unused mode do not count
		taken = 0;
		while (taken < RAND_BEATS) begin
			b = random_beat();
			issue(b);
			if (b.mode != MODE_UNUSED) taken++;
		end

		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (TAIL_CYC) @(posedge clk);
		if (sb.faults == 0) begin
			$display("in_memory_bitwise_row_engine regression: pass");
		end else begin
			$display("in_memory_bitwise_row_engine regression: fail");
		end
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin : watchdog
		#1_000_000;
		$display("in_memory_bitwise_row_engine regression: fail");
		$finish;
	end

endmodule

// ===== files.f =====
src/imbre_pkg.sv
src/imbre_store.sv
src/imbre_alu.sv
src/in_memory_bitwise_row_engine.sv
verif/in_memory_bitwise_row_engine_tb.sv
